FILE: hw/rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [2:0] MODE_PEEK_BACK  = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [WORD_W-1:0] data_in;
    } t_op;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] data_out;
        logic                     is_empty;
    } t_res;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic wr;
        logic load;
        logic shift;
    } t_chain_ctl;

endpackage

FILE: hw/rtl/bounded_array_deque_top.sv
// channel   | ports                      | handshake
// ----------+----------------------------+------------------------------
// op in     | i_op (mode, data_in)       | start, taken when busy low
// result    | o_result (status, data_out,| o_valid, one cycle, no stall
//           |          is_empty)         |
//
// Pushes, errors and unused modes: the accepting edge moves the FSM from
// S_IDLE straight to S_RESP, which raises o_valid; no word overlaps another.
// Pops and peeks: the accepting edge loads the read word into its cell; in
// S_WALK it walks the cell chain from its cell to cell 0 one cell per cycle
// (index up to DEPTH-1), and S_RESP then raises o_valid.
// busy is high from acceptance through the result cycle.
// Reset (sync, active low) empties the queue; stored words are not cleared.
module bounded_array_deque_top #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  bdq_pkg::t_op   i_op,
    output logic           busy,
    output logic           o_valid,
    output bdq_pkg::t_res  o_result
);
    import bdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_chain_ctl        ctl;
    logic [AW-1:0]     wr_idx;
    logic [AW-1:0]     rd_idx;
    logic [WORD_W-1:0] bus [DEPTH+1];

    assign bus[DEPTH] = '0;

    bdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .i_bus0   (bus[0]),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result),
        .o_ctl    (ctl),
        .o_wr_idx (wr_idx),
        .o_rd_idx (rd_idx)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bdq_cell #(
            .AW  (AW),
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_wr_idx   (wr_idx),
            .i_rd_idx   (rd_idx),
            .i_wdata    (i_op.data_in),
            .i_bus_next (bus[g+1]),
            .o_bus      (bus[g])
        );
    end

`ifndef ASSERT_OFF
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |-> (o_result.data_out == '0))
        else $error("nonzero data on error status");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");
`endif

endmodule

FILE: hw/rtl/bdq_cell.sv
module bdq_cell #(
    parameter int AW  = 4,
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  bdq_pkg::t_chain_ctl          i_ctl,
    input  logic [AW-1:0]                i_wr_idx,
    input  logic [AW-1:0]                i_rd_idx,
    input  logic [bdq_pkg::WORD_W-1:0]   i_wdata,
    input  logic [bdq_pkg::WORD_W-1:0]   i_bus_next,
    output logic [bdq_pkg::WORD_W-1:0]   o_bus
);
    import bdq_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_bus;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (i_wr_idx == AW'(IDX))) begin
            r_word <= i_wdata;
        end
    end

    // read bus: selected word is loaded in place, then walks toward cell 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bus <= (i_rd_idx == AW'(IDX)) ? r_word : '0;
        end else if (i_ctl.shift) begin
            r_bus <= i_bus_next;
        end
    end

    assign o_bus = r_bus;

endmodule

FILE: hw/rtl/bdq_ctrl.sv
module bdq_ctrl #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  bdq_pkg::t_op                i_op,
    input  logic [bdq_pkg::WORD_W-1:0]  i_bus0,
    output logic                        busy,
    output logic                        o_valid,
    output bdq_pkg::t_res               o_result,
    output bdq_pkg::t_chain_ctl         o_ctl,
    output logic [AW-1:0]               o_wr_idx,
    output logic [AW-1:0]               o_rd_idx
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_walk,  n_walk;
    logic [1:0]      r_status, n_status;
    logic            r_empty, n_empty;
    logic            r_rd,    n_rd;

    logic            accept;
    logic            nonempty;
    logic [CW-1:0]   rear;
    logic [CW-1:0]   count_dec;
    logic            rd_op;

    assign accept    = start && (r_state == S_IDLE);
    assign nonempty  = (r_count != '0);
    assign rear      = CW'(r_front) + r_count - CW'(1);
    assign count_dec = r_count - CW'(1);

    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_walk   = r_walk;
        n_status = r_status;
        n_empty  = r_empty;
        n_rd     = r_rd;
        o_ctl    = '0;
        o_wr_idx = '0;
        o_rd_idx = '0;
        rd_op    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    unique case (i_op.mode)
                        MODE_PUSH_FRONT: begin
                            if (r_front == '0 || !nonempty) begin
                                n_status = ST_NOROOM;
                            end else begin
                                n_front   = r_front - AW'(1);
                                o_ctl.wr  = 1'b1;
                                o_wr_idx  = r_front - AW'(1);
                                n_count   = r_count + CW'(1);
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (!nonempty) begin
                                n_front  = '0;
                                o_ctl.wr = 1'b1;
                                o_wr_idx = '0;
                                n_count  = CW'(1);
                            end else if (rear >= CW'(DEPTH - 1)) begin
                                n_status = ST_NOROOM;
                            end else begin
                                o_ctl.wr = 1'b1;
                                o_wr_idx = AW'(rear + CW'(1));
                                n_count  = r_count + CW'(1);
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (!nonempty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                rd_op    = 1'b1;
                                o_rd_idx = r_front;
                                n_count  = count_dec;
                                n_front  = (count_dec == '0) ? '0 : r_front + AW'(1);
                            end
                        end
                        MODE_POP_BACK: begin
                            if (!nonempty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                rd_op    = 1'b1;
                                o_rd_idx = AW'(rear);
                                n_count  = count_dec;
                                if (count_dec == '0) begin
                                    n_front = '0;
                                end
                            end
                        end
                        MODE_PEEK_FRONT: begin
                            if (!nonempty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                rd_op    = 1'b1;
                                o_rd_idx = r_front;
                            end
                        end
                        MODE_PEEK_BACK: begin
                            if (!nonempty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                rd_op    = 1'b1;
                                o_rd_idx = AW'(rear);
                            end
                        end
                        default: begin
                        end
                    endcase
                    o_ctl.load = rd_op;
                    n_rd       = rd_op;
                    n_walk     = o_rd_idx;
                    n_empty    = (n_count == '0);
                    n_state    = rd_op ? S_WALK : S_RESP;
                end
            end
            S_WALK: begin
                if (r_walk == '0) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.shift = 1'b1;
                    n_walk      = r_walk - AW'(1);
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk   <= n_walk;
        r_status <= n_status;
        r_empty  <= n_empty;
        r_rd     <= n_rd;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_RESP);
    assign o_result.status   = r_status;
    assign o_result.data_out = r_rd ? i_bus0 : '0;
    assign o_result.is_empty = r_empty;

endmodule

FILE: test/tb.sv
module tb;
    import bdq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int RAND_WORDS = 1030;
    localparam int TAIL_WORDS = 150;
    localparam int LIMIT = 200000;

    typedef struct packed {
        t_op  op;
        logic chk;
        t_res want;
    } t_row;

    // chk set: typed expectation; otherwise the mirror decides
    localparam int N_ROWS = 24;
    t_row dir_rows [0:N_ROWS-1] = '{
        {MODE_POP_FRONT,  32'h00000000, 1'b1, ST_EMPTY,  32'h00000000, 1'b1},
        {MODE_POP_BACK,   32'hFFFFFFFF, 1'b1, ST_EMPTY,  32'h00000000, 1'b1},
        {MODE_PEEK_FRONT, 32'h00000000, 1'b1, ST_EMPTY,  32'h00000000, 1'b1},
        {MODE_PEEK_BACK,  32'h00000000, 1'b1, ST_EMPTY,  32'h00000000, 1'b1},
        {MODE_PUSH_FRONT, 32'h12345678, 1'b1, ST_NOROOM, 32'h00000000, 1'b1},
        {MODE_SPARE6,     32'hFFFFFFFF, 1'b1, ST_OK,     32'h00000000, 1'b1},
        {MODE_SPARE7,     32'h00000000, 1'b1, ST_OK,     32'h00000000, 1'b1},
        {MODE_PUSH_BACK,  32'h7FFFFFFF, 1'b1, ST_OK,     32'h00000000, 1'b0},
        {MODE_PUSH_BACK,  32'h80000000, 1'b1, ST_OK,     32'h00000000, 1'b0},
        {MODE_PEEK_FRONT, 32'h00000000, 1'b1, ST_OK,     32'h7FFFFFFF, 1'b0},
        {MODE_PEEK_BACK,  32'h00000000, 1'b1, ST_OK,     32'h80000000, 1'b0},
        {MODE_PUSH_FRONT, 32'h00000001, 1'b1, ST_NOROOM, 32'h00000000, 1'b0},
        {MODE_POP_FRONT,  32'h00000000, 1'b1, ST_OK,     32'h7FFFFFFF, 1'b0},
        {MODE_PUSH_FRONT, 32'hFFFFFFFF, 1'b1, ST_OK,     32'h00000000, 1'b0},
        {MODE_SPARE7,     32'h00000000, 1'b1, ST_OK,     32'h00000000, 1'b0},
        {MODE_POP_BACK,   32'h00000000, 1'b1, ST_OK,     32'h80000000, 1'b0},
        {MODE_POP_BACK,   32'h00000000, 1'b1, ST_OK,     32'hFFFFFFFF, 1'b1},
        {MODE_PUSH_FRONT, 32'h00000000, 1'b1, ST_NOROOM, 32'h00000000, 1'b1},
        {MODE_PUSH_BACK,  32'h00000000, 1'b1, ST_OK,     32'h00000000, 1'b0},
        {MODE_PUSH_BACK,  32'hA5A5A5A5, 1'b0, ST_OK,     32'h00000000, 1'b0},
        {MODE_POP_FRONT,  32'h00000000, 1'b0, ST_OK,     32'h00000000, 1'b0},
        {MODE_PUSH_FRONT, 32'h5A5A5A5A, 1'b0, ST_OK,     32'h00000000, 1'b0},
        {MODE_PEEK_BACK,  32'h00000000, 1'b0, ST_OK,     32'h00000000, 1'b0},
        {MODE_POP_FRONT,  32'h00000000, 1'b0, ST_OK,     32'h00000000, 1'b0}
    };

    // per-profile mode odds in percent, indexed by mode: fill, refill front, mixed, drain
    int unsigned mode_odds [0:3][0:7] = '{
        '{10, 55,  8,  7,  8,  8, 2, 2},
        '{35, 10, 30,  5,  8,  8, 2, 2},
        '{15, 15, 15, 15, 15, 15, 5, 5},
        '{ 5,  5, 35, 35,  8,  8, 2, 2}
    };

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    t_op    i_op = '0;
    logic   busy;
    logic   o_valid;
    t_res   o_result;

    logic signed [WORD_W-1:0] mirror_words [0:DEPTH-1];
    logic [3:0] mirror_front = '0;
    logic [4:0] mirror_count = '0;

    t_res pending_results [$];
    int   errors = 0;
    int   cycles = 0;

    bounded_array_deque_top #(.DEPTH(DEPTH)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_res deque_apply(t_op op);
        t_res r;
        int   rear;
        r.status   = ST_OK;
        r.data_out = '0;
        rear = (mirror_count != 0) ? int'(mirror_front) + int'(mirror_count) - 1 : 0;
        case (op.mode)
            MODE_PUSH_FRONT: begin
                if (mirror_front == 0 || mirror_count == 0) begin
                    r.status = ST_NOROOM;
                end else begin
                    mirror_front = mirror_front - 1'b1;
                    mirror_words[mirror_front] = op.data_in;
                    mirror_count = mirror_count + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (mirror_count == 0) begin
                    mirror_front = '0;
                    mirror_words[0] = op.data_in;
                    mirror_count = 5'd1;
                end else if (rear >= DEPTH - 1) begin
                    r.status = ST_NOROOM;
                end else begin
                    mirror_words[rear + 1] = op.data_in;
                    mirror_count = mirror_count + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = mirror_words[mirror_front];
                    mirror_count = mirror_count - 1'b1;
                    if (mirror_count == 0)
                        mirror_front = '0;
                    else
                        mirror_front = mirror_front + 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = mirror_words[rear];
                    mirror_count = mirror_count - 1'b1;
                    if (mirror_count == 0)
                        mirror_front = '0;
                end
            end
            MODE_PEEK_FRONT: begin
                if (mirror_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.data_out = mirror_words[mirror_front];
            end
            MODE_PEEK_BACK: begin
                if (mirror_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.data_out = mirror_words[rear];
            end
            default: ;
        endcase
        r.is_empty = (mirror_count == 0);
        return r;
    endfunction

    // holds start until the word is taken, then logs its expected result
    task automatic send_word(input t_op op, input logic chk, input t_res want);
        t_res pred;
        start <= 1'b1;
        i_op  <= op;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = deque_apply(op);
        pending_results.push_back(chk ? want : pred);
    endtask

    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic drain_wait();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status,
                             o_result.status);
                    errors++;
                end
                if (o_result.data_out !== want.data_out) begin
                    $display("%0t: data_out exp %h got %h", $time, want.data_out,
                             o_result.data_out);
                    errors++;
                end
                if (o_result.is_empty !== want.is_empty) begin
                    $display("%0t: is_empty exp %0b got %0b", $time, want.is_empty,
                             o_result.is_empty);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAIL bounded_array_deque_top");
            $finish;
        end
    end

    initial begin
        t_op         op;
        int          profile;
        int          seg_left;
        int unsigned roll;
        int          m;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_ROWS; k++) begin
            send_word(dir_rows[k].op, dir_rows[k].chk, dir_rows[k].want);
            maybe_idle(1'b1);
        end
        drain_wait();

        seg_left = 0;
        profile  = 0;
        for (int k = 0; k < RAND_WORDS; k++) begin
            if (seg_left == 0) begin
                profile  = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 40);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            m = 0;
            while (roll >= mode_odds[profile][m]) begin
                roll -= mode_odds[profile][m];
                m++;
            end
            op.mode = m[2:0];
            case ($urandom_range(0, 11))
                0:       op.data_in = 32'h7FFFFFFF;
                1:       op.data_in = 32'h80000000;
                2:       op.data_in = 32'h00000000;
                3:       op.data_in = 32'hFFFFFFFF;
                default: op.data_in = $urandom;
            endcase
            send_word(op, 1'b0, '0);
            if (k == RAND_WORDS / 2)
                drain_wait();
            else
                maybe_idle(k < RAND_WORDS - TAIL_WORDS);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("PASS bounded_array_deque_top");
        else
            $display("FAIL bounded_array_deque_top");
        $finish;
    end

endmodule
